>>> src/assert_macros.svh
// Assertion macros for the tracker RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every active clock edge.
`define GTN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define GTN_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define GTN_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gtn_pkg.sv
// Types and codes for the grouped top-N tracker.
// Used by the channel interfaces, the ranking cell and the top level.
package gtn_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic [31:0] key;
        logic [30:0] total;
        logic [30:0] clients;
    } entry_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  group;
        logic [2:0]  rank;
        logic [31:0] key_id;
        logic [30:0] total_value;
        logic [30:0] client_count;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  placed_rank;
        logic        entry_valid;
        logic [31:0] entry_key;
        logic [30:0] entry_total;
        logic [30:0] entry_clients;
    } rsp_t;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctl_t;

endpackage

>>> src/gtn_if.sv
// Valid/ready channel interfaces for tracker requests and responses.
// Depends on gtn_pkg for the payload structs.
interface gtn_req_if
    import gtn_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gtn_rsp_if
    import gtn_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/gtn_cell.sv
// One rank position of the tracker, holding that rank's entry for every group.
// Compares against the candidate and takes it or its upper neighbor's entry.
// Depends on gtn_pkg.
module gtn_cell
    import gtn_pkg::*;
#(
    parameter int GROUPS = 4,
    parameter int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic [GW-1:0] grp,
    input  entry_t     cand,
    input  logic       prev_gt,
    input  logic       prev_valid,
    input  entry_t     prev_entry,
    output logic       gt,
    output logic       place,
    output logic       cur_valid,
    output entry_t     cur_entry
);

    logic   valid_reg [GROUPS];
    entry_t entry_reg [GROUPS];
    logic   take_cand;
    logic   take_prev;

    always_comb
    begin
        cur_valid = valid_reg[grp];
        cur_entry = entry_reg[grp];
        gt        = cur_valid && (cur_entry.total > cand.total);
        take_cand = ctl.insert && !gt && prev_gt;
        take_prev = ctl.insert && !gt && !prev_gt;
        place     = take_cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (take_cand)
        begin
            valid_reg[grp] <= 1'b1;
        end
        else if (take_prev)
        begin
            valid_reg[grp] <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cand)
        begin
            entry_reg[grp] <= cand;
        end
        else if (take_prev)
        begin
            entry_reg[grp] <= prev_entry;
        end
    end

endmodule

>>> src/grouped_top_n_tracker_core.sv
// Grouped top-N tracker: GROUPS ranked lists of RANKS entries, sorted by total, largest
// first, ties placing the newer entry above. The row of RANKS cells compares and shifts
// every rank of one group in parallel, so one request is taken per cycle while the
// response output is not held by back-pressure; each response passes through a request
// register and then a response register. Clear empties all groups at once. No clearing
// pass after reset. Depends on gtn_pkg, gtn_if and gtn_cell.
`include "assert_macros.svh"

module grouped_top_n_tracker_core
    import gtn_pkg::*;
#(
    parameter int RANKS  = 8,
    parameter int GROUPS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    gtn_req_if.sink   req,
    gtn_rsp_if.source rsp
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic          req_valid_reg;
    req_t          req_data_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_data_reg;
    rsp_t          rsp_data_next;
    logic          adv;
    logic          fire;
    logic          grp_ok;
    logic [GW-1:0] grp;
    cell_ctl_t     ctl;
    entry_t        cand;

    logic   [RANKS:0] gt_chain;
    logic   [RANKS:0] valid_chain;
    entry_t           entry_chain [RANKS+1];
    logic   [RANKS-1:0] place;

    assign adv       = !rsp_valid_reg || rsp.ready;
    assign fire      = req_valid_reg && adv;
    assign req.ready = !req_valid_reg || adv;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (adv)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_data_reg <= req.data;
        end
        if (fire)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    always_comb
    begin
        grp_ok     = 32'(req_data_reg.group) < GROUPS;
        grp        = GW'({{GW{1'b0}}, req_data_reg.group});
        ctl.insert = fire && grp_ok && (req_data_reg.operation == OP_INSERT);
        ctl.clear  = fire && (req_data_reg.operation == OP_CLEAR);
        cand.key     = req_data_reg.key_id;
        cand.total   = req_data_reg.total_value;
        cand.clients = req_data_reg.client_count;
    end

    assign gt_chain[0]    = 1'b1;
    assign valid_chain[0] = 1'b0;
    assign entry_chain[0] = '0;

    for (genvar i = 0; i < RANKS; i++)
    begin : g_cell
        gtn_cell #(
            .GROUPS (GROUPS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .grp        (grp),
            .cand       (cand),
            .prev_gt    (gt_chain[i]),
            .prev_valid (valid_chain[i]),
            .prev_entry (entry_chain[i]),
            .gt         (gt_chain[i+1]),
            .place      (place[i]),
            .cur_valid  (valid_chain[i+1]),
            .cur_entry  (entry_chain[i+1])
        );
    end

    always_comb
    begin
        rsp_data_next = '0;
        if (req_data_reg.operation == OP_INSERT)
        begin
            rsp_data_next.accepted = |place;
            for (int i = 0; i < RANKS; i++)
            begin
                if (place[i])
                begin
                    rsp_data_next.placed_rank = rsp_data_next.placed_rank | 3'(i);
                end
            end
        end
        else if (req_data_reg.operation == OP_READ && grp_ok)
        begin
            for (int i = 0; i < RANKS && i < 8; i++)
            begin
                if (3'(i) == req_data_reg.rank && valid_chain[i+1])
                begin
                    rsp_data_next.entry_valid   = 1'b1;
                    rsp_data_next.entry_key     = entry_chain[i+1].key;
                    rsp_data_next.entry_total   = entry_chain[i+1].total;
                    rsp_data_next.entry_clients = entry_chain[i+1].clients;
                end
            end
        end
    end

    `GTN_ASSERT(a_place_onehot, $onehot0(place), "more than one rank took the candidate")
    `GTN_IMPLY(a_insert_placed, ctl.insert && !gt_chain[RANKS], |place, "insert with room was not placed")
    `GTN_IMPLY(a_reject_full, ctl.insert && gt_chain[RANKS], place == '0, "rejected insert changed the list")
    `GTN_NEXT(a_req_hold, req_valid_reg && !adv, req_valid_reg, "pending request lost while stalled")
    `GTN_IMPLY(a_rsp_kind, rsp_valid_reg, !(rsp_data_reg.accepted && rsp_data_reg.entry_valid), "response mixes insert and read fields")

endmodule
